### rtl/irar_pkg.sv
// Shared constants and control/status types for the integer-ratio resampler.
`default_nettype none

package irar_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam int RATIO_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd1;

    localparam logic MODE_UP = 1'b0;
    localparam logic MODE_DOWN = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic load_pass;
        logic load_rep;
        logic acc;
        logic clear_group;
        logic div_start;
        logic div_step;
        logic load_quot;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pass;
        logic mode_down;
        logic full;
        logic block_end;
        logic div_done;
        logic rep_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/irar_ctrl.sv
// Sequencing state machine for the resampler: accept, divide, emit.
`default_nettype none

module irar_ctrl
    import irar_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_status.pass) begin
                        o_cmd.load_pass = 1'b1;
                        n_state = S_EMIT;
                    end else if (!i_status.mode_down) begin
                        o_cmd.load_rep = 1'b1;
                        n_state = S_EMIT;
                    end else if (i_status.full) begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end else if (i_status.block_end) begin
                        // drop the partial group
                        o_cmd.clear_group = 1'b1;
                    end else begin
                        o_cmd.acc = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.load_quot = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.rep_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/irar_dp.sv
// Datapath: config registers, group accumulator, serial divider, repeat counter, output register.
`default_nettype none

module irar_dp
    import irar_pkg::*;
#(
    parameter int MAX_RATIO = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire        [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire        [CFG_DATA_W-1:0] i_cfg_data,
    input  wire signed [SAMPLE_W-1:0]   i_sample_in,
    input  wire                         i_block_end,
    input  wire                         i_out_stall,
    input  wire t_cmd                   i_cmd,
    output t_status                     o_status,
    output logic                        o_out_valid,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    output logic                        o_run_last
);

    localparam int R_W = $clog2(MAX_RATIO + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_RATIO) + 1;
    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int CMP_W = (R_W > RATIO_W) ? R_W : RATIO_W;

    logic               r_mode;
    logic [RATIO_W-1:0] r_ratio;
    logic [SUM_W-1:0]   r_sum;
    logic [R_W-1:0]     r_count;
    logic [SUM_W-1:0]   r_dq;
    logic [R_W-1:0]     r_rem;
    logic               r_neg;
    logic [STEP_W-1:0]  r_step;
    logic [SAMPLE_W-1:0] r_val;
    logic [R_W-1:0]     r_tot;
    logic [R_W-1:0]     r_k;
    logic               r_out_valid;

    logic [R_W-1:0]   r_eff;
    logic [SUM_W-1:0] s_ext;
    logic [SUM_W-1:0] total;
    logic [R_W:0]     cnt_inc;
    logic [R_W:0]     rem_sh;
    logic             ge;
    logic [R_W:0]     rem_dif;
    logic [SUM_W-1:0] quot;
    logic [R_W:0]     k_inc;
    logic             out_free;

    // saturate the ratio to what the group counter can hold
    assign r_eff = (CMP_W'(r_ratio) > CMP_W'(MAX_RATIO)) ? R_W'(MAX_RATIO) : R_W'(r_ratio);
    assign s_ext = {{(SUM_W - SAMPLE_W){i_sample_in[SAMPLE_W-1]}}, i_sample_in};
    assign total = r_sum + s_ext;
    assign cnt_inc = {1'b0, r_count} + {{R_W{1'b0}}, 1'b1};

    assign rem_sh = {r_rem, r_dq[SUM_W-1]};
    assign ge = rem_sh >= {1'b0, r_eff};
    assign rem_dif = rem_sh - {1'b0, r_eff};
    assign quot = r_neg ? (~r_dq + {{(SUM_W-1){1'b0}}, 1'b1}) : r_dq;

    assign k_inc = {1'b0, r_k} + {{R_W{1'b0}}, 1'b1};
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_status.pass = r_eff <= R_W'(1);
    assign o_status.mode_down = (r_mode == MODE_DOWN);
    assign o_status.full = cnt_inc >= {1'b0, r_eff};
    assign o_status.block_end = i_block_end;
    assign o_status.div_done = (r_step == STEP_W'(SUM_W));
    assign o_status.rep_last = (k_inc == {1'b0, r_tot});
    assign o_status.out_free = out_free;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UP;
            r_ratio <= '0;
            r_sum <= '0;
            r_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DIRECTION) begin
                    r_mode <= i_cfg_data[0];
                    r_sum <= '0;
                    r_count <= '0;
                end else if (i_cfg_idx == CFG_RATIO) begin
                    r_ratio <= i_cfg_data[RATIO_W-1:0];
                    r_sum <= '0;
                    r_count <= '0;
                end
            end else if (i_cmd.acc) begin
                r_sum <= total;
                r_count <= cnt_inc[R_W-1:0];
            end else if (i_cmd.clear_group || i_cmd.div_start) begin
                r_sum <= '0;
                r_count <= '0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= total[SUM_W-1];
            r_dq <= total[SUM_W-1] ? (~total + {{(SUM_W-1){1'b0}}, 1'b1}) : total;
            r_rem <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_dq <= {r_dq[SUM_W-2:0], ge};
            r_rem <= ge ? rem_dif[R_W-1:0] : rem_sh[R_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end

        if (i_cmd.load_pass) begin
            r_val <= i_sample_in;
            r_tot <= R_W'(1);
            r_k <= '0;
        end else if (i_cmd.load_rep) begin
            r_val <= i_sample_in;
            r_tot <= r_eff;
            r_k <= '0;
        end else if (i_cmd.load_quot) begin
            r_val <= quot[SAMPLE_W-1:0];
            r_tot <= R_W'(1);
            r_k <= '0;
        end else if (i_cmd.emit) begin
            r_k <= k_inc[R_W-1:0];
        end

        if (i_cmd.emit) begin
            o_sample_out <= r_val;
            o_run_last <= (k_inc == {1'b0, r_tot});
        end
    end

endmodule

`default_nettype wire

### rtl/integer_ratio_audio_resampler.sv
// Integer-ratio audio resampler: repeat on playback, boxcar average on capture.
// Up mode: each item is accepted, then repeated r times, one repeat per cycle while the
// output is free, r = ratio capped at MAX_RATIO. Pass through (ratio 0 or 1): one out per item.
// Down mode: mid-group items are accumulated back to back; a group-closing item is run
// through the SUM_W-bit, one-bit-per-cycle restoring divider (SUM_W = 16 + clog2(MAX_RATIO) + 1).
// Reset is synchronous: mode up, ratio 0, group cleared, output empty.
`default_nettype none

module integer_ratio_audio_resampler
    import irar_pkg::*;
#(
    parameter int MAX_RATIO = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire        [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire        [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire signed [SAMPLE_W-1:0]   i_sample_in,
    input  wire                         i_block_end,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic signed [SAMPLE_W-1:0]  o_sample_out,
    output logic                        o_run_last
);

    t_cmd    cmd;
    t_status status;

    assign o_in_stall = !cmd.in_ready;

    irar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    irar_dp #(
        .MAX_RATIO (MAX_RATIO)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_block_end  (i_block_end),
        .i_out_stall  (i_out_stall),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_run_last   (o_run_last)
    );

endmodule

`default_nettype wire
